/* hdl/dfb_pkg.sv */
// Shared types, constants and the exp table builder for the depth fog blend block.
package dfb_pkg;

    localparam int DEPTH_W  = 24;
    localparam int DENS_W   = 16;
    localparam int COLOR_W  = 8;
    localparam int NUM_CH   = 3;
    localparam int CFG_DW   = 32;
    localparam int PADDR_W  = 5;

    // fog factor, Q1.16: one integer bit so that 1.0 fits
    localparam int               F_W   = 17;
    localparam logic [F_W-1:0]   F_ONE = 17'h1_0000;

    localparam int PROD_W = DEPTH_W + DENS_W;
    localparam int T_FRAC = 24;
    localparam int T_W    = 29;
    localparam logic [T_W-1:0] T_MAX = 29'h1000_0000;
    localparam int U_W    = 27;
    localparam logic [U_W-1:0] U_MAX = 27'h400_0000;
    localparam int SQ_W   = 2 * U_W - 1;
    localparam int TSQ_W  = SQ_W - T_FRAC;

    localparam int EXP_ENTRIES  = 256;
    localparam int EXP_K_W      = $clog2(EXP_ENTRIES + 1);
    localparam int POS_W        = T_W + EXP_K_W;
    localparam int POS_K_LSB    = 28;
    localparam int KR_W         = POS_W - POS_K_LSB;
    localparam int FRAC_W       = 16;
    localparam int FRAC_LSB     = 12;
    localparam int IP_W         = F_W + FRAC_W;
    localparam int ROUND_HALF   = 32768;
    localparam int TAYLOR_TERMS = 12;
    localparam int SQUARINGS    = 5;

    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = FRAC_W / DIV_BITS;
    localparam int EXP_CORE     = 5;
    localparam int EXP_PAD      = DIV_STAGES - EXP_CORE;
    localparam int BLEND_STAGES = 3;
    localparam int PIPE_STAGES  = 1 + DIV_STAGES + BLEND_STAGES;

    localparam int BL_W = F_W + COLOR_W;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [DEPTH_W-1:0] RST_FOG_END  = 24'd4096;
    localparam logic [DENS_W-1:0]  RST_DENSITY  = 16'd4096;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_EXP    = 2'd1,
        MODE_EXP2   = 2'd2,
        MODE_NONE   = 2'd3
    } t_fog_mode;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_START   = 3'd1,
        REG_END     = 3'd2,
        REG_DENSITY = 3'd3,
        REG_RED     = 3'd4,
        REG_GREEN   = 3'd5,
        REG_BLUE    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        LIN_ZERO = 2'd0,
        LIN_ONE  = 2'd1,
        LIN_DIV  = 2'd2
    } t_lin_cls;

    typedef struct packed {
        t_fog_mode          factor_mode;
        logic [DEPTH_W-1:0] start_depth;
        logic [DEPTH_W-1:0] fog_end;
        logic [DENS_W-1:0]  density;
        logic [COLOR_W-1:0] fog_red;
        logic [COLOR_W-1:0] fog_green;
        logic [COLOR_W-1:0] fog_blue;
    } t_cfg;

    typedef struct packed {
        t_lin_cls          cls;
        logic [FRAC_W-1:0] quot;
    } t_lin_res;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] in_red;
        logic [COLOR_W-1:0] in_green;
        logic [COLOR_W-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] out_alpha;
    } t_out_item;

    // exp(-16*idx/N) in Q1.16: Taylor series of exp(-idx/(2N)) in Q0.31,
    // squared five times, then rounded to 16 fraction bits
    function automatic logic [F_W-1:0] f_exp_entry(input int unsigned idx);
        logic [63:0] v_s;
        logic [63:0] v_sum;
        logic [63:0] v_term;
        logic [63:0] v_prod;
        v_s    = (64'(idx) << 30) / EXP_ENTRIES;
        v_sum  = 64'h8000_0000;
        v_term = 64'h8000_0000;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            v_prod = (v_term * v_s) >> 31;
            case (n)
                2:       v_term = v_prod / 2;
                3:       v_term = v_prod / 3;
                4:       v_term = v_prod / 4;
                5:       v_term = v_prod / 5;
                6:       v_term = v_prod / 6;
                7:       v_term = v_prod / 7;
                8:       v_term = v_prod / 8;
                9:       v_term = v_prod / 9;
                10:      v_term = v_prod / 10;
                11:      v_term = v_prod / 11;
                12:      v_term = v_prod / 12;
                default: v_term = v_prod;
            endcase
            if (n[0]) begin
                v_sum = v_sum - v_term;
            end else begin
                v_sum = v_sum + v_term;
            end
        end
        for (int q = 0; q < SQUARINGS; q++) begin
            v_sum = (v_sum * v_sum + 64'h4000_0000) >> 31;
        end
        return F_W'((v_sum + 64'd16384) >> 15);
    endfunction

endpackage

/* hdl/dfb_cfg.sv */
// APB register file holding fog mode, linear range, density and fog color.
module dfb_cfg
    import dfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factor_mode <= MODE_LINEAR;
            r_cfg.start_depth <= '0;
            r_cfg.fog_end     <= RST_FOG_END;
            r_cfg.density     <= RST_DENSITY;
            r_cfg.fog_red     <= '0;
            r_cfg.fog_green   <= '0;
            r_cfg.fog_blue    <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE:    r_cfg.factor_mode <= t_fog_mode'(pwdata[1:0]);
                REG_START:   r_cfg.start_depth <= pwdata[DEPTH_W-1:0];
                REG_END:     r_cfg.fog_end     <= pwdata[DEPTH_W-1:0];
                REG_DENSITY: r_cfg.density     <= pwdata[DENS_W-1:0];
                REG_RED:     r_cfg.fog_red     <= pwdata[COLOR_W-1:0];
                REG_GREEN:   r_cfg.fog_green   <= pwdata[COLOR_W-1:0];
                REG_BLUE:    r_cfg.fog_blue    <= pwdata[COLOR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:    prdata = CFG_DW'(r_cfg.factor_mode);
            REG_START:   prdata = CFG_DW'(r_cfg.start_depth);
            REG_END:     prdata = CFG_DW'(r_cfg.fog_end);
            REG_DENSITY: prdata = CFG_DW'(r_cfg.density);
            REG_RED:     prdata = CFG_DW'(r_cfg.fog_red);
            REG_GREEN:   prdata = CFG_DW'(r_cfg.fog_green);
            REG_BLUE:    prdata = CFG_DW'(r_cfg.fog_blue);
            default:     prdata = '0;
        endcase
    end

endmodule

/* hdl/dfb_div.sv */
// Pipelined restoring divider for the linear fog factor, two quotient bits per stage.
module dfb_div
    import dfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic [DEPTH_W-1:0] i_rem,
    input  logic [DEPTH_W-1:0] i_den,
    input  t_lin_cls           i_cls,
    output t_lin_res           o_res
);

    logic [DEPTH_W-1:0] r_rem [DIV_STAGES];
    logic [DEPTH_W-1:0] r_den [DIV_STAGES];
    logic [FRAC_W-1:0]  r_q   [DIV_STAGES];
    t_lin_cls           r_cls [DIV_STAGES];
    logic [DEPTH_W-1:0] n_rem [DIV_STAGES];
    logic [FRAC_W-1:0]  n_q   [DIV_STAGES];

    // remainder stays below the divisor, so doubling it fits one extra bit
    always_comb begin
        logic [DEPTH_W-1:0] v_rem;
        logic [DEPTH_W-1:0] v_den;
        logic [FRAC_W-1:0]  v_q;
        logic [DEPTH_W:0]   v_try;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                v_rem = i_rem;
                v_den = i_den;
                v_q   = '0;
            end else begin
                v_rem = r_rem[s-1];
                v_den = r_den[s-1];
                v_q   = r_q[s-1];
            end
            for (int b = 0; b < DIV_BITS; b++) begin
                v_try = {v_rem, 1'b0};
                if (v_try >= {1'b0, v_den}) begin
                    v_try = v_try - {1'b0, v_den};
                    v_q   = {v_q[FRAC_W-2:0], 1'b1};
                end else begin
                    v_q   = {v_q[FRAC_W-2:0], 1'b0};
                end
                v_rem = v_try[DEPTH_W-1:0];
            end
            n_rem[s] = v_rem;
            n_q[s]   = v_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_den[0] <= i_den;
            r_cls[0] <= i_cls;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_den[s] <= r_den[s-1];
                r_cls[s] <= r_cls[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_res.cls  = r_cls[DIV_STAGES-1];
    assign o_res.quot = r_q[DIV_STAGES-1];

endmodule

/* hdl/dfb_exp.sv */
// Exponential fog factor: clamp, square, table lookup and interpolation.
module dfb_exp
    import dfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [PROD_W-1:0] i_prod,
    input  t_fog_mode         i_mode,
    output logic [F_W-1:0]    o_f
);

    logic [F_W-1:0]     w_rom [EXP_ENTRIES+1];

    logic [T_W-1:0]     w_t1;
    logic [U_W-1:0]     w_u;
    logic [T_W-1:0]     r_e2_t;
    logic [SQ_W-1:0]    r_e2_sq;

    logic [TSQ_W-1:0]   w_tsq;
    logic [T_W-1:0]     w_tsq_c;
    logic [T_W-1:0]     w_t;
    logic [POS_W-1:0]   w_pos;
    logic [KR_W-1:0]    w_kraw;
    logic [EXP_K_W-1:0] w_k;
    logic [EXP_K_W-1:0] r_e3_k;
    logic [FRAC_W-1:0]  r_e3_frac;

    logic [F_W-1:0]     w_a;
    logic [F_W-1:0]     w_b;
    logic [F_W-1:0]     r_e4_a;
    logic [F_W-1:0]     r_e4_d;
    logic [FRAC_W-1:0]  r_e4_frac;

    logic [F_W-1:0]     r_e5_a;
    logic [IP_W-1:0]    r_e5_p;

    logic [IP_W-1:0]    w_rnd;
    logic [F_W-1:0]     r_e6_f;
    logic [F_W-1:0]     r_pad [EXP_PAD];

    for (genvar g = 0; g <= EXP_ENTRIES; g++) begin : g_rom
        assign w_rom[g] = f_exp_entry(g);
    end

    // stage 1: saturate density*depth for both modes, square for exp2
    assign w_t1 = (i_prod > PROD_W'(T_MAX)) ? T_MAX : i_prod[T_W-1:0];
    assign w_u  = (i_prod > PROD_W'(U_MAX)) ? U_MAX : i_prod[U_W-1:0];

    // stage 2: pick t, split into table index and interpolation fraction
    assign w_tsq   = r_e2_sq[SQ_W-1:T_FRAC];
    assign w_tsq_c = (w_tsq > TSQ_W'(T_MAX)) ? T_MAX : T_W'(w_tsq);
    assign w_t     = (i_mode == MODE_EXP2) ? w_tsq_c : r_e2_t;
    assign w_pos   = POS_W'(w_t) * POS_W'(EXP_ENTRIES);
    assign w_kraw  = w_pos[POS_W-1:POS_K_LSB];
    assign w_k     = (w_kraw > KR_W'(EXP_ENTRIES)) ? EXP_K_W'(EXP_ENTRIES)
                                                  : w_kraw[EXP_K_W-1:0];

    // stage 3: read both neighbors; at the last entry the slope is zero
    assign w_a = w_rom[r_e3_k];
    assign w_b = (r_e3_k < EXP_K_W'(EXP_ENTRIES)) ? w_rom[r_e3_k + 1'b1] : w_a;

    // stage 5: round the interpolation step and subtract
    assign w_rnd = r_e5_p + IP_W'(ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e2_t    <= w_t1;
            r_e2_sq   <= SQ_W'(w_u) * SQ_W'(w_u);
            r_e3_k    <= w_k;
            r_e3_frac <= w_pos[POS_K_LSB-1:FRAC_LSB];
            r_e4_a    <= w_a;
            r_e4_d    <= w_a - w_b;
            r_e4_frac <= r_e3_frac;
            r_e5_a    <= r_e4_a;
            r_e5_p    <= IP_W'(r_e4_d) * IP_W'(r_e4_frac);
            r_e6_f    <= r_e5_a - w_rnd[IP_W-1:FRAC_W];
            r_pad[0]  <= r_e6_f;
            for (int i = 1; i < EXP_PAD; i++) begin
                r_pad[i] <= r_pad[i-1];
            end
        end
    end

    assign o_f = r_pad[EXP_PAD-1];

endmodule

/* hdl/dfb_blend.sv */
// Factor select and per-channel blend toward the fog color, with the output register.
module dfb_blend
    import dfb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_adv,
    input  t_lin_res       i_lin,
    input  logic [F_W-1:0] i_f_exp,
    input  t_rgb           i_pix,
    input  t_cfg           i_cfg,
    output t_out_item      o_data
);

    logic [F_W-1:0]     w_f_lin;
    logic [F_W-1:0]     w_f;
    logic [F_W-1:0]     r_f;
    logic [F_W-1:0]     r_g;
    t_rgb               r_pix;
    logic [COLOR_W-1:0] w_p   [NUM_CH];
    logic [COLOR_W-1:0] w_c   [NUM_CH];
    logic [BL_W-1:0]    r_pf  [NUM_CH];
    logic [BL_W-1:0]    r_pc  [NUM_CH];
    logic [BL_W:0]      w_sum [NUM_CH];
    t_out_item          r_out;

    always_comb begin
        case (i_lin.cls)
            LIN_ONE: w_f_lin = F_ONE;
            LIN_DIV: w_f_lin = {1'b0, i_lin.quot};
            default: w_f_lin = '0;
        endcase
        case (i_cfg.factor_mode)
            MODE_LINEAR: w_f = w_f_lin;
            MODE_EXP:    w_f = i_f_exp;
            MODE_EXP2:   w_f = i_f_exp;
            default:     w_f = '0;
        endcase
    end

    assign w_p[0] = r_pix.red;
    assign w_p[1] = r_pix.green;
    assign w_p[2] = r_pix.blue;
    assign w_c[0] = i_cfg.fog_red;
    assign w_c[1] = i_cfg.fog_green;
    assign w_c[2] = i_cfg.fog_blue;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_sum[ch] = (BL_W+1)'(r_pf[ch]) + (BL_W+1)'(r_pc[ch])
                      + (BL_W+1)'(ROUND_HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_f   <= w_f;
            r_g   <= F_ONE - w_f;
            r_pix <= i_pix;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_pf[ch] <= BL_W'(r_f) * BL_W'(w_p[ch]);
                r_pc[ch] <= BL_W'(r_g) * BL_W'(w_c[ch]);
            end
            r_out.out_red   <= w_sum[0][FRAC_W +: COLOR_W];
            r_out.out_green <= w_sum[1][FRAC_W +: COLOR_W];
            r_out.out_blue  <= w_sum[2][FRAC_W +: COLOR_W];
            r_out.out_alpha <= ALPHA_OPAQUE;
        end
    end

    assign o_data = r_out;

endmodule

/* hdl/depth_fog_blend_core.sv */
// Depth fog blend top level: input stage, factor pipelines, blend and APB registers.
// One pixel per clock while the output is not stalled. The pipeline depth is set by the
// linear-mode divider, which resolves two quotient bits in each of its eight stages. All
// stages hold together while the output transaction is stalled; bubbles are carried,
// not squeezed out. Registers are to be written only while no transaction is in flight.
module depth_fog_blend_core
    import dfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg                   w_cfg;
    logic                   w_adv;
    logic [PIPE_STAGES-1:0] r_vld;

    logic [DEPTH_W-1:0]     w_z;
    logic                   w_num_neg;
    logic                   w_den_neg;
    logic [DEPTH_W-1:0]     w_num;
    logic [DEPTH_W-1:0]     w_den;
    t_lin_cls               w_cls;

    logic [PROD_W-1:0]      r_s1_prod;
    logic [DEPTH_W-1:0]     r_s1_rem;
    logic [DEPTH_W-1:0]     r_s1_den;
    t_lin_cls               r_s1_cls;
    t_rgb                   r_pix [DIV_STAGES+1];

    t_lin_res               w_lin;
    logic [F_W-1:0]         w_f_exp;

    dfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // hold every stage while the output transaction waits
    assign w_adv       = !(r_vld[PIPE_STAGES-1] && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[PIPE_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_in_valid};
        end
    end

    // linear mode: settle the saturated and zero cases before the divider
    assign w_z       = i_in_data.depth;
    assign w_num_neg = w_z > w_cfg.fog_end;
    assign w_num     = w_num_neg ? (w_z - w_cfg.fog_end) : (w_cfg.fog_end - w_z);
    assign w_den_neg = w_cfg.start_depth > w_cfg.fog_end;
    assign w_den     = w_den_neg ? (w_cfg.start_depth - w_cfg.fog_end)
                                 : (w_cfg.fog_end - w_cfg.start_depth);

    always_comb begin
        if (w_cfg.fog_end == w_cfg.start_depth) begin
            w_cls = (w_z < w_cfg.fog_end) ? LIN_ONE : LIN_ZERO;
        end else if (w_num == '0 || w_num_neg != w_den_neg) begin
            w_cls = LIN_ZERO;
        end else if (w_num >= w_den) begin
            w_cls = LIN_ONE;
        end else begin
            w_cls = LIN_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod      <= PROD_W'(w_cfg.density) * PROD_W'(w_z);
            r_s1_rem       <= w_num;
            r_s1_den       <= w_den;
            r_s1_cls       <= w_cls;
            r_pix[0].red   <= i_in_data.in_red;
            r_pix[0].green <= i_in_data.in_green;
            r_pix[0].blue  <= i_in_data.in_blue;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                r_pix[i] <= r_pix[i-1];
            end
        end
    end

    dfb_div u_div (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_rem (r_s1_rem),
        .i_den (r_s1_den),
        .i_cls (r_s1_cls),
        .o_res (w_lin)
    );

    dfb_exp u_exp (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_prod (r_s1_prod),
        .i_mode (w_cfg.factor_mode),
        .o_f    (w_f_exp)
    );

    dfb_blend u_blend (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_lin   (w_lin),
        .i_f_exp (w_f_exp),
        .i_pix   (r_pix[DIV_STAGES]),
        .i_cfg   (w_cfg),
        .o_data  (o_out_data)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved while the pipeline was held");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_vld[0] == $past(i_in_valid))
        else $error("input transaction lost or invented at pipeline entry");

    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_vld[PIPE_STAGES-1:1] == $past(r_vld[PIPE_STAGES-2:0]))
        else $error("valid bits did not advance one stage");

endmodule

/* test/depth_fog_blend_check.sv */
// Result checker for the depth fog blend block: tracks register writes, predicts and compares.
`timescale 1ns / 1ps
module depth_fog_blend_check
    import dfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [CFG_DW-1:0]  i_pwdata,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int MAX_REPORTS = 40;

    logic [F_W-1:0]     decay_rom [0:EXP_ENTRIES];
    t_fog_mode          cfg_mode    = MODE_LINEAR;
    logic [DEPTH_W-1:0] cfg_start   = '0;
    logic [DEPTH_W-1:0] cfg_end     = RST_FOG_END;
    logic [DENS_W-1:0]  cfg_density = RST_DENSITY;
    t_rgb               cfg_fog     = '0;
    t_out_item          fogged_q[$];
    int                 errors      = 0;
    int                 reports     = 0;
    int                 pend_count  = 0;

    assign o_errors  = errors;
    assign o_pending = pend_count;

    // exp(-16*idx/N) in Q1.16 from a series for exp(-idx/(2N)) squared five times
    function automatic logic [F_W-1:0] decay_entry(input int unsigned idx);
        logic [63:0] s;
        logic [63:0] sum;
        logic [63:0] term;
        s    = (64'(idx) << 30) / 64'(EXP_ENTRIES);
        sum  = 64'h8000_0000;
        term = 64'h8000_0000;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * s) >> 31) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int sq = 0; sq < SQUARINGS; sq++) begin
            sum = (sum * sum + 64'h4000_0000) >> 31;
        end
        return F_W'((sum + 64'd16384) >> 15);
    endfunction

    initial begin
        for (int i = 0; i <= EXP_ENTRIES; i++) begin
            decay_rom[i] = decay_entry(i);
        end
    end

    // interpolate exp(-t) for t in Q.24, already limited to 16
    function automatic logic [F_W-1:0] decay_of(input logic [63:0] t);
        logic [63:0] pos;
        logic [63:0] k;
        logic [63:0] frac;
        logic [63:0] a;
        logic [63:0] b;
        pos  = t * 64'(EXP_ENTRIES);
        k    = pos >> 28;
        frac = (pos >> 12) & 64'hFFFF;
        if (k > 64'(EXP_ENTRIES)) begin
            k = 64'(EXP_ENTRIES);
        end
        a = 64'(decay_rom[k]);
        b = (k < 64'(EXP_ENTRIES)) ? 64'(decay_rom[k + 1]) : a;
        return F_W'(a - (((a - b) * frac + 64'd32768) >> 16));
    endfunction

    function automatic logic [F_W-1:0] linear_fog(input logic [DEPTH_W-1:0] z);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic        num_neg;
        logic        den_neg;
        if (cfg_end == cfg_start) begin
            return (z < cfg_end) ? F_ONE : '0;
        end
        num_neg = z > cfg_end;
        num     = num_neg ? 64'(z - cfg_end) : 64'(cfg_end - z);
        den_neg = cfg_start > cfg_end;
        den     = den_neg ? 64'(cfg_start - cfg_end) : 64'(cfg_end - cfg_start);
        if (num == 0 || num_neg != den_neg) begin
            return '0;
        end
        q = (num << 16) / den;
        return (q > 64'(F_ONE)) ? F_ONE : F_W'(q);
    endfunction

    function automatic logic [F_W-1:0] fog_factor(input logic [DEPTH_W-1:0] z);
        logic [63:0] u;
        logic [63:0] t;
        case (cfg_mode)
            MODE_LINEAR: begin
                return linear_fog(z);
            end
            MODE_EXP: begin
                t = 64'(cfg_density) * 64'(z);
                if (t > 64'(T_MAX)) begin
                    t = 64'(T_MAX);
                end
                return decay_of(t);
            end
            MODE_EXP2: begin
                u = 64'(cfg_density) * 64'(z);
                if (u > 64'(U_MAX)) begin
                    u = 64'(U_MAX);
                end
                t = (u * u) >> 24;
                if (t > 64'(T_MAX)) begin
                    t = 64'(T_MAX);
                end
                return decay_of(t);
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] mix_channel(input logic [F_W-1:0] f,
                                                      input logic [COLOR_W-1:0] p,
                                                      input logic [COLOR_W-1:0] c);
        logic [63:0] acc;
        acc = 64'(f) * 64'(p) + (64'(F_ONE) - 64'(f)) * 64'(c) + 64'd32768;
        return acc[23:16];
    endfunction

    function automatic t_out_item fogged_pixel(input t_in_item px);
        t_out_item      res;
        logic [F_W-1:0] f;
        f             = fog_factor(px.depth);
        res.out_red   = mix_channel(f, px.in_red, cfg_fog.red);
        res.out_green = mix_channel(f, px.in_green, cfg_fog.green);
        res.out_blue  = mix_channel(f, px.in_blue, cfg_fog.blue);
        res.out_alpha = ALPHA_OPAQUE;
        return res;
    endfunction

    task automatic compare_field(input string fname, input logic [COLOR_W-1:0] want,
                                 input logic [COLOR_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (reports < MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
            end
            reports++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_mode    <= MODE_LINEAR;
            cfg_start   <= '0;
            cfg_end     <= RST_FOG_END;
            cfg_density <= RST_DENSITY;
            cfg_fog     <= '0;
            fogged_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                // drop writes to addresses past the register list
                case (i_paddr[PADDR_W-1:2])
                    REG_MODE:    cfg_mode      <= t_fog_mode'(i_pwdata[1:0]);
                    REG_START:   cfg_start     <= i_pwdata[DEPTH_W-1:0];
                    REG_END:     cfg_end       <= i_pwdata[DEPTH_W-1:0];
                    REG_DENSITY: cfg_density   <= i_pwdata[DENS_W-1:0];
                    REG_RED:     cfg_fog.red   <= i_pwdata[COLOR_W-1:0];
                    REG_GREEN:   cfg_fog.green <= i_pwdata[COLOR_W-1:0];
                    REG_BLUE:    cfg_fog.blue  <= i_pwdata[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                fogged_q.push_back(fogged_pixel(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (fogged_q.size() == 0) begin
                    errors++;
                    if (reports < MAX_REPORTS) begin
                        $display("%0t: unexpected transaction: expected none, got %h",
                                 $time, i_out_data);
                    end
                    reports++;
                end else begin
                    want = fogged_q.pop_front();
                    compare_field("out_red", want.out_red, i_out_data.out_red);
                    compare_field("out_green", want.out_green, i_out_data.out_green);
                    compare_field("out_blue", want.out_blue, i_out_data.out_blue);
                    compare_field("out_alpha", want.out_alpha, i_out_data.out_alpha);
                end
            end
        end
        pend_count <= fogged_q.size();
    end

endmodule

/* test/depth_fog_blend_core_test.sv */
// Testbench top for the depth fog blend block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module depth_fog_blend_core_test;
    import dfb_pkg::*;

    localparam int RANDOM_PHASES  = 20;
    localparam int PHASE_ITEMS    = 96;
    localparam int QUIET_PHASES   = 3;
    localparam int PRESSURE_PHASE = 6;
    localparam int HOLD_CYCLES    = 150;
    localparam int LATENCY        = 11;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [PADDR_W-1:0] UNUSED_REG_ADDR = PADDR_W'(4 * (int'(REG_BLUE) + 1));

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [CFG_DW-1:0]  pwdata    = '0;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;
    int                 errors;
    int                 pending;

    bit                 src_idle_en   = 1'b0;
    bit                 sink_idle_en  = 1'b0;
    bit                 sink_hold_req = 1'b0;
    bit                 hold_used     = 1'b0;
    int                 hold_left     = 0;
    int                 burst_left    = 0;
    int                 quiet_cycles  = 0;

    t_fog_mode          cur_mode    = MODE_LINEAR;
    logic [DEPTH_W-1:0] cur_start   = '0;
    logic [DEPTH_W-1:0] cur_end     = RST_FOG_END;
    logic [DENS_W-1:0]  cur_density = RST_DENSITY;

    depth_fog_blend_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    depth_fog_blend_check fog_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #2 i_clk = ~i_clk;

    // output stall: one long hold on request, otherwise short random bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (sink_hold_req && !hold_used) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (burst_left > 0) begin
            out_stall  <= 1'b1;
            burst_left <= burst_left - 1;
        end else begin
            out_stall <= 1'b0;
            if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                burst_left <= $urandom_range(1, 14);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in_item pixel(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] r,
                                       input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
        t_in_item px;
        px.depth    = d;
        px.in_red   = r;
        px.in_green = g;
        px.in_blue  = b;
        return px;
    endfunction

    function automatic logic [COLOR_W-1:0] random_level();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return '0;
        end
        if (pick == 1) begin
            return '1;
        end
        return COLOR_W'($urandom_range(0, 255));
    endfunction

    // aim most depths at the part of the range where the fog factor moves
    function automatic logic [DEPTH_W-1:0] random_depth();
        logic [DEPTH_W-1:0] lo;
        logic [DEPTH_W-1:0] hi;
        logic [63:0]        reach;
        int unsigned        pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return ($urandom_range(0, 1) == 1) ? '1 : '0;
        end
        if (pick < 3 || cur_mode == MODE_NONE) begin
            return DEPTH_W'($urandom());
        end
        if (cur_mode == MODE_LINEAR) begin
            lo = (cur_start < cur_end) ? cur_start : cur_end;
            hi = (cur_start < cur_end) ? cur_end : cur_start;
            lo = (lo > 64) ? lo - 64 : '0;
            hi = (hi < 24'hFFFFBF) ? hi + 64 : '1;
            return DEPTH_W'($urandom_range(lo, hi));
        end
        if (cur_density == 0) begin
            return DEPTH_W'($urandom());
        end
        reach = ((cur_mode == MODE_EXP) ? 64'(T_MAX) : 64'(U_MAX)) * 5 / (4 * 64'(cur_density));
        if (reach > 64'hFFFFFF) begin
            reach = 64'hFFFFFF;
        end
        return DEPTH_W'($urandom_range(0, 32'(reach)));
    endfunction

    function automatic logic [CFG_DW-1:0] with_noise(input logic [CFG_DW-1:0] v, input int w);
        return (CFG_DW'($urandom()) << w) | v;
    endfunction

    // leave psel and pwrite high so that writes can follow back to back
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_fog(input t_fog_mode mode, input logic [DEPTH_W-1:0] fstart,
                               input logic [DEPTH_W-1:0] fend, input logic [DENS_W-1:0] dens,
                               input logic [COLOR_W-1:0] fr, input logic [COLOR_W-1:0] fg,
                               input logic [COLOR_W-1:0] fb, input bit poke_spare);
        reg_write({REG_MODE, 2'b00}, with_noise(CFG_DW'(mode), 2));
        reg_write({REG_START, 2'b00}, with_noise(CFG_DW'(fstart), DEPTH_W));
        reg_write({REG_END, 2'b00}, with_noise(CFG_DW'(fend), DEPTH_W));
        reg_write({REG_DENSITY, 2'b00}, with_noise(CFG_DW'(dens), DENS_W));
        reg_write({REG_RED, 2'b00}, with_noise(CFG_DW'(fr), COLOR_W));
        reg_write({REG_GREEN, 2'b00}, with_noise(CFG_DW'(fg), COLOR_W));
        reg_write({REG_BLUE, 2'b00}, with_noise(CFG_DW'(fb), COLOR_W));
        if (poke_spare) begin
            reg_write(UNUSED_REG_ADDR, $urandom());
        end
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        cur_mode    = mode;
        cur_start   = fstart;
        cur_end     = fend;
        cur_density = dens;
    endtask

    task automatic send_pixel(input t_in_item px);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge i_clk); while (in_stall);
    endtask

    // drain every pending transaction, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register values straight out of reset: linear from 0 to 1.0, black fog
        send_pixel(pixel(24'h000000, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel(24'h000800, 8'hC8, 8'h64, 8'h01));
        send_pixel(pixel(24'h001000, 8'hFF, 8'h00, 8'hFF));
        send_pixel(pixel(24'hFFFFFF, 8'h00, 8'hFF, 8'h00));
        settle();

        // start equal to end: full pixel below, full fog at and above
        program_fog(MODE_LINEAR, 24'h001000, 24'h001000, RST_DENSITY, 8'hFF, 8'h00, 8'h80,
                    1'b0);
        send_pixel(pixel(24'h000FFF, 8'h12, 8'hFF, 8'h00));
        send_pixel(pixel(24'h001000, 8'h12, 8'hFF, 8'h00));
        send_pixel(pixel(24'h001001, 8'hFF, 8'h00, 8'hFF));
        send_pixel(pixel(24'h000000, 8'h00, 8'hFF, 8'h7F));
        settle();

        // start above end
        program_fog(MODE_LINEAR, 24'hFFFFFF, 24'h000000, RST_DENSITY, 8'h40, 8'hC0, 8'hFF,
                    1'b0);
        send_pixel(pixel(24'h000000, 8'hFF, 8'h00, 8'h00));
        send_pixel(pixel(24'h800000, 8'h00, 8'hFF, 8'h80));
        send_pixel(pixel(24'hFFFFFF, 8'hAA, 8'h55, 8'h00));
        settle();

        // exp: zero depth, t exactly at the table end, mid table, saturated
        program_fog(MODE_EXP, 24'h000000, 24'h001000, 16'h1000, 8'd10, 8'd20, 8'd30, 1'b0);
        send_pixel(pixel(24'h000000, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel(24'h010000, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel(24'h000800, 8'hF0, 8'h0F, 8'h99));
        send_pixel(pixel(24'hFFFFFF, 8'hFF, 8'h00, 8'hFF));
        settle();

        // exp2 at full density: clamped product, tiny step, zero
        program_fog(MODE_EXP2, 24'h000000, 24'h001000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(pixel(24'h001000, 8'h00, 8'h00, 8'h00));
        send_pixel(pixel(24'h000001, 8'h00, 8'h80, 8'hFF));
        send_pixel(pixel(24'h000000, 8'h00, 8'h01, 8'h02));
        settle();

        program_fog(MODE_EXP2, 24'h000000, 24'h001000, 16'h1000, 8'h20, 8'h00, 8'hE0, 1'b0);
        send_pixel(pixel(24'h002000, 8'hFF, 8'h80, 8'h00));
        send_pixel(pixel(24'h004000, 8'hFF, 8'h80, 8'h00));
        settle();

        // no fog factor: output is the fog colour; also poke the unused address
        program_fog(MODE_NONE, 24'h123456, 24'hABCDEF, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(pixel(24'h000000, 8'h00, 8'h00, 8'h00));
        send_pixel(pixel(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF));
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            logic [DEPTH_W-1:0] fs;
            logic [DEPTH_W-1:0] fe;
            logic [DENS_W-1:0]  dens;
            case ($urandom_range(0, 4))
                0: begin
                    fs = DEPTH_W'($urandom());
                    fe = DEPTH_W'($urandom());
                end
                1: begin
                    fs = DEPTH_W'($urandom_range(0, 24'hFF0000));
                    fe = fs + DEPTH_W'($urandom_range(1, 24'h8000));
                end
                2: begin
                    fs = DEPTH_W'($urandom());
                    fe = fs;
                end
                3: begin
                    fs = '0;
                    fe = '1;
                end
                default: begin
                    fs = '1;
                    fe = '0;
                end
            endcase
            case ($urandom_range(0, 3))
                0:       dens = '0;
                1:       dens = '1;
                default: dens = DENS_W'($urandom_range(1, 16'h4000));
            endcase
            program_fog(t_fog_mode'(p % 4), fs, fe, dens, random_level(), random_level(),
                        random_level(), $urandom_range(0, 7) == 0);
            src_idle_en = (p < RANDOM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            sink_idle_en <= (p < RANDOM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            if (p == PRESSURE_PHASE) begin
                // keep offering while the output holds off, so the pipe fills
                src_idle_en = 1'b0;
                sink_hold_req <= 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                send_pixel(pixel(random_depth(), random_level(), random_level(),
                                 random_level()));
            end
            settle();
        end

        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
